[design/dpf_pkg.sv]
package dpf_pkg;

    localparam int DEPTH_DEF = 256;
    localparam int CFG_W     = 9;
    localparam int CNT_W     = 9;
    localparam logic [CFG_W-1:0] LIMIT_RST = 9'd256;

    localparam logic [1:0] MODE_ADD = 2'd0;
    localparam logic [1:0] MODE_FWD = 2'd1;
    localparam logic [1:0] MODE_CNT = 2'd2;

    typedef struct packed {
        logic [15:0] src;
        logic [15:0] dst;
        logic [31:0] stamp;
    } t_entry;

    typedef struct packed {
        logic dup;
        logic in_win;
    } t_match;

endpackage

[design/dpf_match.sv]
module dpf_match
    import dpf_pkg::*;
(
    input  t_entry      i_entry,
    input  t_entry      i_key,
    input  logic [31:0] i_lo,
    input  logic [31:0] i_hi,
    output t_match      o_match
);

    always_comb begin
        o_match.dup    = (i_entry == i_key);
        o_match.in_win = (i_entry.dst == i_key.dst) &&
                         (i_entry.stamp >= i_lo) && (i_entry.stamp <= i_hi);
    end

endmodule

[design/dedup_packet_fifo_with_range_count_top.sv]
// Deduplicating bounded packet FIFO with a destination/time range count.
// Input channel (i_in_valid/o_in_ready) carries one command word: mode,
// packet fields and count window. Output channel (o_out_valid/i_out_ready)
// returns one result word per command. Config channel (i_cfg_valid/
// o_cfg_ready) writes capacity_limit; it is always ready. The user writes it
// only while the block is idle; the block does not enforce this.
// Add and count walk every stored entry through one memory read port and one
// shared compare unit, one entry per cycle (add and count scan all stored
// entries, forward of a nonempty store scans one; nothing is scanned for an
// empty store, an empty window or an unused mode). A new word can be accepted
// in the cycle after the result is loaded, and not before: the block takes
// no word while it is still working on the last one.
// A stalled receiver holds the result in the output register; a following
// command may be accepted and scanned, then waits until the register frees.
// Reset empties the store (head and occupancy cleared, limit back to 256);
// the entry memory is not cleared.
module dedup_packet_fifo_with_range_count_top
    import dpf_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_valid,
    output logic             o_cfg_ready,
    input  logic [CFG_W-1:0] i_cfg_data,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  logic [1:0]       i_mode,
    input  logic [15:0]      i_src_node,
    input  logic [15:0]      i_dst_node,
    input  logic [31:0]      i_stamp,
    input  logic [31:0]      i_range_start,
    input  logic [31:0]      i_range_end,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output logic             o_ok,
    output logic [15:0]      o_out_src,
    output logic [15:0]      o_out_dst,
    output logic [31:0]      o_out_stamp,
    output logic [CNT_W-1:0] o_match_count
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int OW = $clog2(DEPTH + 1);
    localparam int CW = (OW > CFG_W) ? OW : CFG_W;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_SCAN = 2'd1;
    localparam logic [1:0] ST_FIN  = 2'd2;

    logic [1:0]       r_state, n_state;
    logic [AW-1:0]    r_head, n_head;
    logic [OW-1:0]    r_occ, n_occ;
    logic [CFG_W-1:0] r_limit;
    logic [AW-1:0]    r_addr, n_addr;
    logic [OW-1:0]    r_cnt, n_cnt;
    logic [OW-1:0]    r_len, n_len;
    logic             r_hit, n_hit;
    logic [CNT_W-1:0] r_n, n_n;
    logic             r_rd_vld;
    t_entry           r_rd;
    logic [1:0]       r_mode;
    t_entry           r_key;
    logic [31:0]      r_lo, r_hi;
    t_entry           r_mem [DEPTH];

    logic             rd_en, wr_en, fin_go, full;
    logic [CFG_W-1:0] lim_eff;
    t_match           cmp;

    logic             n_ok;
    logic [15:0]      n_out_src;
    logic [15:0]      n_out_dst;
    logic [31:0]      n_out_stamp;
    logic [CNT_W-1:0] n_match_count;

    function automatic logic [AW-1:0] wrap_inc(input logic [AW-1:0] a);
        return (a == AW'(DEPTH - 1)) ? '0 : a + 1'b1;
    endfunction

    dpf_match u_match (
        .i_entry (r_rd),
        .i_key   (r_key),
        .i_lo    (r_lo),
        .i_hi    (r_hi),
        .o_match (cmp)
    );

    assign o_cfg_ready = 1'b1;
    assign o_in_ready  = (r_state == ST_IDLE);

    assign lim_eff = (r_limit == '0) ? CFG_W'(1) : r_limit;
    assign full    = (CW'(r_occ) >= CW'(lim_eff)) || (r_occ == OW'(DEPTH));
    assign rd_en   = (r_state == ST_SCAN) && (r_cnt != r_len);
    assign fin_go  = (r_state == ST_FIN) && (!o_out_valid || i_out_ready);
    assign wr_en   = fin_go && (r_mode == MODE_ADD) && !r_hit;

    always_comb begin
        n_state = r_state;
        n_head  = r_head;
        n_occ   = r_occ;
        n_addr  = r_addr;
        n_cnt   = r_cnt;
        n_len   = r_len;
        n_hit   = r_hit;
        n_n     = r_n;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = ST_SCAN;
                    n_addr  = r_head;
                    n_cnt   = '0;
                    n_hit   = 1'b0;
                    n_n     = '0;
                    case (i_mode)
                        MODE_ADD: n_len = r_occ;
                        MODE_FWD: n_len = (r_occ != '0) ? OW'(1) : '0;
                        MODE_CNT: n_len = (i_range_start <= i_range_end) ? r_occ : '0;
                        default:  n_len = '0;
                    endcase
                end
            end
            ST_SCAN: begin
                if (rd_en) begin
                    n_addr = wrap_inc(r_addr);
                    n_cnt  = r_cnt + 1'b1;
                end
                if (r_rd_vld) begin
                    if (cmp.dup) begin
                        n_hit = 1'b1;
                    end
                    if (cmp.in_win && (r_n != '1)) begin
                        n_n = r_n + 1'b1;
                    end
                end
                if (!rd_en && !r_rd_vld) begin
                    n_state = ST_FIN;
                end
            end
            ST_FIN: begin
                if (fin_go) begin
                    n_state = ST_IDLE;
                    if (r_mode == MODE_ADD && !r_hit) begin
                        if (full) begin
                            n_head = wrap_inc(r_head);
                        end else begin
                            n_occ = r_occ + 1'b1;
                        end
                    end else if (r_mode == MODE_FWD && r_occ != '0) begin
                        n_head = wrap_inc(r_head);
                        n_occ  = r_occ - 1'b1;
                    end
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_head   <= '0;
            r_occ    <= '0;
            r_limit  <= LIMIT_RST;
            r_rd_vld <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_head   <= n_head;
            r_occ    <= n_occ;
            r_rd_vld <= rd_en;
            if (i_cfg_valid) begin
                r_limit <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_addr <= n_addr;
        r_cnt  <= n_cnt;
        r_len  <= n_len;
        r_hit  <= n_hit;
        r_n    <= n_n;
        if (o_in_ready && i_in_valid) begin
            r_mode <= i_mode;
            r_key  <= '{src: i_src_node, dst: i_dst_node, stamp: i_stamp};
            r_lo   <= i_range_start;
            r_hi   <= i_range_end;
        end
    end

    // entry memory: one read, one write port
    always_ff @(posedge i_clk) begin
        if (rd_en) begin
            r_rd <= r_mem[r_addr];
        end
        if (wr_en) begin
            r_mem[r_addr] <= r_key;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_out_valid <= 1'b0;
        end else if (fin_go) begin
            o_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            o_out_valid <= 1'b0;
        end
    end

    always_comb begin
        n_ok          = 1'b0;
        n_out_src     = '0;
        n_out_dst     = '0;
        n_out_stamp   = '0;
        n_match_count = '0;
        case (r_mode)
            MODE_ADD: n_ok = !r_hit;
            MODE_FWD: begin
                if (r_occ != '0) begin
                    n_ok        = 1'b1;
                    n_out_src   = r_rd.src;
                    n_out_dst   = r_rd.dst;
                    n_out_stamp = r_rd.stamp;
                end
            end
            MODE_CNT: n_match_count = r_n;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (fin_go) begin
            o_ok          <= n_ok;
            o_out_src     <= n_out_src;
            o_out_dst     <= n_out_dst;
            o_out_stamp   <= n_out_stamp;
            o_match_count <= n_match_count;
        end
    end

    a_occ_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_occ <= OW'(DEPTH))
        else $error("occupancy above depth");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("ready right after accept");

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SCAN) |-> (r_cnt <= r_len))
        else $error("scan ran past its length");

    a_rd_in_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rd_vld |-> (r_state == ST_SCAN))
        else $error("read data outside scan");

endmodule

[test/dpf_checker.sv]
module dpf_checker
    import dpf_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_valid,
    input  logic             i_cfg_ready,
    input  logic [CFG_W-1:0] i_cfg_data,
    input  logic             i_in_valid,
    input  logic             i_in_ready,
    input  logic [1:0]       i_mode,
    input  logic [15:0]      i_src_node,
    input  logic [15:0]      i_dst_node,
    input  logic [31:0]      i_stamp,
    input  logic [31:0]      i_range_start,
    input  logic [31:0]      i_range_end,
    input  logic             i_out_valid,
    input  logic             i_out_ready,
    input  logic             i_ok,
    input  logic [15:0]      i_out_src,
    input  logic [15:0]      i_out_dst,
    input  logic [31:0]      i_out_stamp,
    input  logic [CNT_W-1:0] i_match_count,
    output int               o_pending,
    output int               o_errors
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic             ok;
        logic [15:0]      src;
        logic [15:0]      dst;
        logic [31:0]      stamp;
        logic [CNT_W-1:0] count;
    } t_result;

    t_entry           held_packets[$];
    t_result          expected_results[$];
    logic [CFG_W-1:0] limit_copy;
    t_result          predicted;
    t_result          oldest;

    task automatic apply_command(input logic [1:0] mode, input t_entry pkt,
                                 input logic [31:0] lo, input logic [31:0] hi,
                                 output t_result res);
        int     lim;
        int     hits;
        bit     dup;
        t_entry head;
        res = '0;
        lim = (limit_copy == 0) ? 1 : ((limit_copy > DEPTH) ? DEPTH : int'(limit_copy));
        case (mode)
            MODE_ADD: begin
                dup = 0;
                foreach (held_packets[i]) begin
                    if (held_packets[i] == pkt) dup = 1;
                end
                if (!dup) begin
                    if (held_packets.size() >= lim) held_packets.delete(0);
                    held_packets.insert(held_packets.size(), pkt);
                    res.ok = 1'b1;
                end
            end
            MODE_FWD: begin
                if (held_packets.size() != 0) begin
                    head = held_packets[0];
                    held_packets.delete(0);
                    res.ok    = 1'b1;
                    res.src   = head.src;
                    res.dst   = head.dst;
                    res.stamp = head.stamp;
                end
            end
            MODE_CNT: begin
                hits = 0;
                if (lo <= hi) begin
                    foreach (held_packets[i]) begin
                        if (held_packets[i].dst == pkt.dst && held_packets[i].stamp >= lo &&
                            held_packets[i].stamp <= hi) hits++;
                    end
                end
                if (hits > 511) hits = 511;
                res.count = hits[CNT_W-1:0];
            end
            default: ;
        endcase
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            $display("%0t ns: %s mismatch: expected 0x%0h, actual 0x%0h",
                     $time, name, want, got);
            o_errors++;
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            held_packets.delete();
            expected_results.delete();
            limit_copy = LIMIT_RST;
            o_errors   = 0;
        end else begin
            if (i_out_valid && i_out_ready) begin
                if (expected_results.size() == 0) begin
                    $display("%0t ns: result word with no command outstanding", $time);
                    o_errors++;
                end else begin
                    oldest = expected_results[0];
                    expected_results.delete(0);
                    check_field("ok", 32'(oldest.ok), 32'(i_ok));
                    check_field("out_src", 32'(oldest.src), 32'(i_out_src));
                    check_field("out_dst", 32'(oldest.dst), 32'(i_out_dst));
                    check_field("out_stamp", oldest.stamp, i_out_stamp);
                    check_field("match_count", 32'(oldest.count), 32'(i_match_count));
                end
            end
            if (i_cfg_valid && i_cfg_ready) limit_copy = i_cfg_data;
            if (i_in_valid && i_in_ready) begin
                apply_command(i_mode, '{i_src_node, i_dst_node, i_stamp},
                              i_range_start, i_range_end, predicted);
                expected_results.insert(expected_results.size(), predicted);
            end
        end
        o_pending = expected_results.size();
    end

endmodule

[test/testbench.sv]
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import dpf_pkg::*;

    localparam logic [1:0] MODE_UNUSED = 2'd3;

    logic             i_clk = 1'b0;
    logic             i_rst_n;
    logic             i_cfg_valid;
    logic             o_cfg_ready;
    logic [CFG_W-1:0] i_cfg_data;
    logic             i_in_valid;
    logic             o_in_ready;
    logic [1:0]       i_mode;
    logic [15:0]      i_src_node;
    logic [15:0]      i_dst_node;
    logic [31:0]      i_stamp;
    logic [31:0]      i_range_start;
    logic [31:0]      i_range_end;
    logic             o_out_valid;
    logic             i_out_ready;
    logic             o_ok;
    logic [15:0]      o_out_src;
    logic [15:0]      o_out_dst;
    logic [31:0]      o_out_stamp;
    logic [CNT_W-1:0] o_match_count;

    int     pending_n;
    int     mismatch_n;
    t_entry recent_adds[16];
    int     recent_n = 0;
    int     burst_left = 0;
    bit     no_idle = 0;
    int     phase_limit[9] = '{256, 511, 257, 1, 2, 16, -1, 64, 255};

    always #1 i_clk = ~i_clk;

    dedup_packet_fifo_with_range_count_top u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_mode        (i_mode),
        .i_src_node    (i_src_node),
        .i_dst_node    (i_dst_node),
        .i_stamp       (i_stamp),
        .i_range_start (i_range_start),
        .i_range_end   (i_range_end),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_ok          (o_ok),
        .o_out_src     (o_out_src),
        .o_out_dst     (o_out_dst),
        .o_out_stamp   (o_out_stamp),
        .o_match_count (o_match_count)
    );

    dpf_checker u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .i_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data),
        .i_in_valid    (i_in_valid),
        .i_in_ready    (o_in_ready),
        .i_mode        (i_mode),
        .i_src_node    (i_src_node),
        .i_dst_node    (i_dst_node),
        .i_stamp       (i_stamp),
        .i_range_start (i_range_start),
        .i_range_end   (i_range_end),
        .i_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .i_ok          (o_ok),
        .i_out_src     (o_out_src),
        .i_out_dst     (o_out_dst),
        .i_out_stamp   (o_out_stamp),
        .i_match_count (o_match_count),
        .o_pending     (pending_n),
        .o_errors      (mismatch_n)
    );

    function automatic t_entry pk(input logic [15:0] s, input logic [15:0] d,
                                  input logic [31:0] t);
        return '{s, d, t};
    endfunction

    function automatic logic [15:0] rand_node();
        case ($urandom_range(0, 9))
            0:             return 16'h0000;
            1:             return 16'hFFFF;
            2, 3, 4, 5, 6: return 16'($urandom_range(0, 3));
            default:       return 16'($urandom);
        endcase
    endfunction

    function automatic logic [31:0] rand_stamp();
        case ($urandom_range(0, 9))
            0:             return 32'h0000_0000;
            1:             return 32'hFFFF_FFFF;
            2, 3, 4, 5, 6: return 32'($urandom_range(0, 15));
            default:       return $urandom;
        endcase
    endfunction

    task automatic send_word(input logic [1:0] mode, input t_entry pkt,
                             input logic [31:0] lo, input logic [31:0] hi, input int gap);
        i_in_valid    <= 1'b1;
        i_mode        <= mode;
        i_src_node    <= pkt.src;
        i_dst_node    <= pkt.dst;
        i_stamp       <= pkt.stamp;
        i_range_start <= lo;
        i_range_end   <= hi;
        do @(posedge i_clk); while (!o_in_ready);
        if (mode == MODE_ADD) begin
            recent_adds[recent_n % 16] = pkt;
            recent_n++;
        end
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // hold off until every issued word has been answered
    task automatic wait_drained();
        i_in_valid <= 1'b0;
        do @(negedge i_clk); while (pending_n != 0);
        @(posedge i_clk);
    endtask

    task automatic write_limit(input logic [CFG_W-1:0] value);
        wait_drained();
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic send_random_word(input int add_pct, input int fwd_pct, input int gap);
        logic [1:0]  mode;
        t_entry      pkt;
        logic [31:0] lo;
        logic [31:0] hi;
        logic [31:0] a;
        logic [31:0] b;
        int          r;
        int          hist_sz;
        r = $urandom_range(0, 99);
        if (r < add_pct) mode = MODE_ADD;
        else if (r < add_pct + fwd_pct) mode = MODE_FWD;
        else if (r < 95) mode = MODE_CNT;
        else mode = MODE_UNUSED;
        pkt     = pk(rand_node(), rand_node(), rand_stamp());
        hist_sz = (recent_n < 16) ? recent_n : 16;
        if (mode == MODE_ADD && hist_sz > 0 && $urandom_range(0, 3) == 0)
            pkt = recent_adds[$urandom_range(0, hist_sz - 1)];
        a = $urandom_range(0, 15);
        b = $urandom_range(0, 15);
        case ($urandom_range(0, 9))
            0: begin
                lo = '0;
                hi = '1;
            end
            1: begin
                lo = $urandom_range(1, 15);
                hi = $urandom_range(0, lo - 1);
            end
            2, 3: begin
                lo = a;
                hi = a;
            end
            4, 5, 6: begin
                lo = (a < b) ? a : b;
                hi = (a < b) ? b : a;
            end
            default: begin
                lo = $urandom;
                hi = $urandom;
            end
        endcase
        send_word(mode, pkt, lo, hi, gap);
    endtask

    // receiver back-pressure, switching at random among four styles
    initial begin
        int kind;
        int left;
        int hold;
        kind        = 0;
        left        = 0;
        hold        = 0;
        i_out_ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (left == 0) begin
                kind = $urandom_range(0, 3);
                left = $urandom_range(64, 600);
            end
            left--;
            case (kind)
                0: i_out_ready <= 1'b1;
                1: i_out_ready <= 1'($urandom_range(0, 1));
                2: i_out_ready <= (left % 8 == 0);
                default: begin
                    if (hold > 0) begin
                        hold--;
                        i_out_ready <= 1'b0;
                    end else begin
                        hold = $urandom_range(0, 40);
                        i_out_ready <= 1'b1;
                    end
                end
            endcase
        end
    end

    initial begin
        int add_pct;
        int fwd_pct;
        int gap;
        i_rst_n       = 1'b0;
        i_cfg_valid   = 1'b0;
        i_cfg_data    = '0;
        i_in_valid    = 1'b0;
        i_mode        = MODE_ADD;
        i_src_node    = '0;
        i_dst_node    = '0;
        i_stamp       = '0;
        i_range_start = '0;
        i_range_end   = '0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // empty store, unused mode, field extremes, duplicate of the oldest entry
        send_word(MODE_FWD, pk(16'h1234, 16'h5678, 32'h9ABC), 32'h5, 32'h3, 0);
        send_word(MODE_CNT, pk(16'h0, 16'h0, 32'h0), 32'h0, 32'hFFFF_FFFF, 0);
        send_word(MODE_UNUSED, pk(16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF),
                  32'hFFFF_FFFF, 32'hFFFF_FFFF, 0);
        send_word(MODE_ADD, pk(16'h0, 16'h0, 32'h0), 32'h0, 32'h0, 0);
        send_word(MODE_ADD, pk(16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF), 32'h0, 32'h0, 0);
        send_word(MODE_ADD, pk(16'h0, 16'h0, 32'h0), 32'h0, 32'h0, 0);
        send_word(MODE_CNT, pk(16'h0, 16'hFFFF, 32'h0), 32'h0, 32'hFFFF_FFFF, 0);
        send_word(MODE_CNT, pk(16'h0, 16'h0, 32'h0), 32'h0, 32'h0, 0);
        send_word(MODE_CNT, pk(16'h0, 16'hFFFF, 32'h0), 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0);
        send_word(MODE_CNT, pk(16'h0, 16'h0, 32'h0), 32'h1, 32'h0, 0);
        send_word(MODE_FWD, pk(16'h0, 16'h0, 32'h0), 32'h0, 32'h0, 0);
        send_word(MODE_FWD, pk(16'h0, 16'h0, 32'h0), 32'h0, 32'h0, 0);
        send_word(MODE_FWD, pk(16'h0, 16'h0, 32'h0), 32'h0, 32'h0, 0);

        // zero limit behaves as one
        write_limit(9'd0);
        send_word(MODE_ADD, pk(16'd1, 16'd2, 32'd3), 32'h0, 32'h0, 0);
        send_word(MODE_ADD, pk(16'd4, 16'd2, 32'd6), 32'h0, 32'h0, 0);
        send_word(MODE_FWD, pk(16'h0, 16'h0, 32'h0), 32'h0, 32'h0, 0);

        // limit lowered below occupancy
        write_limit(9'd3);
        send_word(MODE_ADD, pk(16'd1, 16'd2, 32'd3), 32'h0, 32'h0, 0);
        send_word(MODE_ADD, pk(16'd4, 16'd2, 32'd6), 32'h0, 32'h0, 0);
        send_word(MODE_ADD, pk(16'd7, 16'd2, 32'd9), 32'h0, 32'h0, 0);
        write_limit(9'd1);
        send_word(MODE_ADD, pk(16'd8, 16'd2, 32'd10), 32'h0, 32'h0, 0);
        send_word(MODE_CNT, pk(16'h0, 16'd2, 32'h0), 32'h0, 32'hFFFF_FFFF, 0);
        send_word(MODE_FWD, pk(16'h0, 16'h0, 32'h0), 32'h0, 32'h0, 0);
        send_word(MODE_FWD, pk(16'h0, 16'h0, 32'h0), 32'h0, 32'h0, 0);

        for (int p = 0; p < 9; p++) begin
            if (phase_limit[p] < 0) write_limit(9'($urandom_range(0, 511)));
            else write_limit(9'(phase_limit[p]));
            add_pct = $urandom_range(25, 55);
            fwd_pct = $urandom_range(10, 30);
            if (p == 4) begin
                add_pct = 15;
                fwd_pct = 60;
            end
            no_idle = ($urandom_range(0, 3) == 0);
            for (int n = 0; n < 150; n++) begin
                if (p == 2 && n == 75) wait_drained();
                if (burst_left == 0) burst_left = $urandom_range(1, 24);
                gap = (burst_left == 1 && !no_idle) ? $urandom_range(1, 12) : 0;
                burst_left--;
                send_random_word(add_pct, fwd_pct, gap);
            end
        end

        wait_drained();
        repeat (300) @(posedge i_clk);
        if (mismatch_n == 0 && pending_n == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

    initial begin
        #6000000;
        $display("Verification failed");
        $finish;
    end

endmodule

[sim.f]
design/dpf_pkg.sv
design/dpf_match.sv
design/dedup_packet_fifo_with_range_count_top.sv
test/dpf_checker.sv
test/testbench.sv
